@@ rtl/ptc_pkg.sv @@
// Package for the pressure/temperature trim compensation block.
// Holds register indexes, pipeline depth and arithmetic constants.
// No dependencies.
`timescale 1ns / 1ps

package ptc_pkg;

   typedef enum logic [1:0] {
      CSR_TRIM_TEMP    = 2'd0,
      CSR_TRIM_PRESS_A = 2'd1,
      CSR_TRIM_PRESS_B = 2'd2,
      CSR_TRIM_PRESS_C = 2'd3
   } ptc_csr_type;

   localparam int DIV_BITS     = 64;
   localparam int FRONT_STAGES = 11;
   localparam int BACK_STAGES  = 6;
   localparam int LATENCY      = FRONT_STAGES + DIV_BITS + BACK_STAGES;

   localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
   localparam logic signed [25:0] FINE_OFFSET = 26'sd128000;
   localparam logic [11:0]        PRESS_SCALE = 12'd3125;
   localparam logic [63:0]        X_BIAS      = 64'd1 << 47;

endpackage

@@ rtl/pressure_temperature_compensation.sv @@
// Trim compensation, fully pipelined: one item per cycle outside reset.
// 11 front stages (temperature and divisor), a 64-stage restoring divider
// (one quotient bit per stage), 6 back stages (pressure terms, output reg).
// Results appear for one cycle on rsp_valid; the receiver cannot stall.
// Synchronous active-high reset clears valid bits and trim registers; busy
// is high only during reset.
`timescale 1ns / 1ps

module pressure_temperature_compensation import ptc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   output logic        req_busy,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   output logic        rsp_valid,
   output logic [31:0] rsp_temperature_centi,
   output logic [31:0] rsp_fine_temperature,
   output logic [31:0] rsp_pressure_q24_8,
   output logic        rsp_divide_fault,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   typedef struct packed {
      logic [31:0] temp;
      logic [24:0] fine;
   } side_type;

   typedef struct packed {
      logic        v;
      logic [30:0] rem;
      logic [63:0] dvd;
      logic [30:0] mag_d;
      logic        neg;
      logic        fault;
      side_type    side;
   } div_stage_type;

   // ---------------- trim registers ----------------
   logic [47:0] trim_temp_ff;
   logic [63:0] trim_press_a_ff, trim_press_b_ff;
   logic [15:0] trim_press_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_temp_ff    <= '0;
         trim_press_a_ff <= '0;
         trim_press_b_ff <= '0;
         trim_press_c_ff <= '0;
      end else if (csr_we) begin
         unique case (ptc_csr_type'(csr_index))
            CSR_TRIM_TEMP:    trim_temp_ff    <= csr_wdata[47:0];
            CSR_TRIM_PRESS_A: trim_press_a_ff <= csr_wdata;
            CSR_TRIM_PRESS_B: trim_press_b_ff <= csr_wdata;
            CSR_TRIM_PRESS_C: trim_press_c_ff <= csr_wdata[15:0];
         endcase
      end
   end

   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = trim_temp_ff[15:0];
   assign t2 = trim_temp_ff[31:16];
   assign t3 = trim_temp_ff[47:32];
   assign p1 = trim_press_a_ff[15:0];
   assign p2 = trim_press_a_ff[31:16];
   assign p3 = trim_press_a_ff[47:32];
   assign p4 = trim_press_a_ff[63:48];
   assign p5 = trim_press_b_ff[15:0];
   assign p6 = trim_press_b_ff[31:16];
   assign p7 = trim_press_b_ff[47:32];
   assign p8 = trim_press_b_ff[63:48];
   assign p9 = trim_press_c_ff;

   assign req_busy = reset;

   // ---------------- front valid line ----------------
   // one bit per stage S1..S10; the divider input register holds the last
   logic [FRONT_STAGES-2:0] fv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else begin
         fv_ff <= {fv_ff[FRONT_STAGES-3:0], req_start & ~req_busy};
      end
   end

   // S1: temperature differences and first products
   logic signed [17:0] x1;
   logic signed [16:0] d1;
   logic signed [33:0] s1_mt2_in, s1_dd_in, s1_mt2_ff, s1_dd_ff;
   logic [20:0]        s1_pp_in, s1_pp_ff;
   assign x1 = $signed({1'b0, req_raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
   assign d1 = $signed({1'b0, req_raw_temperature[19:4]}) - $signed({1'b0, t1});
   assign s1_mt2_in = x1 * t2;
   assign s1_dd_in  = d1 * d1;
   assign s1_pp_in  = PRESS_FULL - {1'b0, req_raw_pressure};

   // S2
   logic signed [21:0] dd12;
   logic signed [22:0] s2_at_ff;
   logic signed [37:0] s2_m3_in, s2_m3_ff;
   logic [20:0]        s2_pp_ff;
   assign dd12     = s1_dd_ff[33:12];
   assign s2_m3_in = dd12 * t3;

   // S3: fine temperature
   logic signed [24:0] s3_fine_in;
   logic [24:0]        s3_fine_ff;
   logic [20:0]        s3_pp_ff;
   assign s3_fine_in = $signed({{2{s2_at_ff[22]}}, s2_at_ff})
                     + $signed({s2_m3_ff[37], s2_m3_ff[37:14]});

   // S4: temperature output and pressure offset
   logic signed [28:0] f5;
   logic signed [25:0] s4_pa_in, s4_pa_ff;
   side_type           s4_side_in, s4_side_ff;
   logic [20:0]        s4_pp_ff;
   assign f5 = $signed({{4{s3_fine_ff[24]}}, s3_fine_ff})
             + $signed({{2{s3_fine_ff[24]}}, s3_fine_ff, 2'b00}) + 29'sd128;
   assign s4_pa_in        = $signed({s3_fine_ff[24], s3_fine_ff}) - FINE_OFFSET;
   assign s4_side_in.temp = {{11{f5[28]}}, f5[28:8]};
   assign s4_side_in.fine = s3_fine_ff;

   // S5
   logic signed [51:0] s5_aa_in, s5_aa_ff;
   logic signed [41:0] s5_ap5_in, s5_ap2_in, s5_ap5_ff, s5_ap2_ff;
   side_type           s5_side_ff;
   logic [20:0]        s5_pp_ff;
   assign s5_aa_in  = s4_pa_ff * s4_pa_ff;
   assign s5_ap5_in = s4_pa_ff * p5;
   assign s5_ap2_in = s4_pa_ff * p2;

   // S6
   logic signed [67:0] s6_m6_in, s6_m3b_in, s6_m6_ff, s6_m3b_ff;
   logic signed [41:0] s6_ap5_ff, s6_ap2_ff;
   side_type           s6_side_ff;
   logic [20:0]        s6_pp_ff;
   assign s6_m6_in  = s5_aa_ff * p6;
   assign s6_m3b_in = s5_aa_ff * p3;

   // S7: b term and divisor operand, modulo 2^64
   logic [63:0] s7_b_in, s7_x_in, s7_b_ff, s7_x_ff;
   side_type    s7_side_ff;
   logic [20:0] s7_pp_ff;
   assign s7_b_in = s6_m6_ff[63:0]
                  + ({{22{s6_ap5_ff[41]}}, s6_ap5_ff} << 17)
                  + ({{48{p4[15]}}, p4} << 35);
   assign s7_x_in = X_BIAS + {{4{s6_m3b_ff[67]}}, s6_m3b_ff[67:8]}
                  + ({{22{s6_ap2_ff[41]}}, s6_ap2_ff} << 12);

   // S8: split products by p1, dividend before scaling
   logic [47:0] s8_lo_in, s8_hi_in, s8_lo_ff, s8_hi_ff;
   logic [63:0] s8_n0_in, s8_n0_ff;
   side_type    s8_side_ff;
   assign s8_lo_in = s7_x_ff[31:0] * p1;
   assign s8_hi_in = s7_x_ff[63:32] * p1;
   assign s8_n0_in = {12'b0, s7_pp_ff, 31'b0} - s7_b_ff;

   // S9
   logic [63:0] prod;
   logic [30:0] s9_div_ff;
   logic [43:0] s9_nl_in, s9_nh_in, s9_nl_ff, s9_nh_ff;
   side_type    s9_side_ff;
   assign prod     = {16'b0, s8_lo_ff} + {s8_hi_ff[31:0], 32'b0};
   assign s9_nl_in = s8_n0_ff[31:0] * PRESS_SCALE;
   assign s9_nh_in = s8_n0_ff[63:32] * PRESS_SCALE;

   // S10
   logic [63:0] s10_n_in, s10_n_ff;
   logic [30:0] s10_div_ff;
   side_type    s10_side_ff;
   assign s10_n_in = {20'b0, s9_nl_ff} + {s9_nh_ff[31:0], 32'b0};

   // S11: magnitudes into divider
   div_stage_type div_ff [DIV_BITS+1];
   div_stage_type div0_in;
   always_comb begin
      div0_in.v     = fv_ff[FRONT_STAGES-2];
      div0_in.rem   = '0;
      div0_in.dvd   = s10_n_ff[63] ? (~s10_n_ff + 64'd1) : s10_n_ff;
      div0_in.mag_d = s10_div_ff[30] ? (~s10_div_ff + 31'd1) : s10_div_ff;
      div0_in.neg   = s10_n_ff[63] ^ s10_div_ff[30];
      div0_in.fault = (s10_div_ff == '0);
      div0_in.side  = s10_side_ff;
   end

   always_ff @(posedge clock) begin
      s1_mt2_ff  <= s1_mt2_in;
      s1_dd_ff   <= s1_dd_in;
      s1_pp_ff   <= s1_pp_in;
      s2_at_ff   <= s1_mt2_ff[33:11];
      s2_m3_ff   <= s2_m3_in;
      s2_pp_ff   <= s1_pp_ff;
      s3_fine_ff <= s3_fine_in;
      s3_pp_ff   <= s2_pp_ff;
      s4_pa_ff   <= s4_pa_in;
      s4_side_ff <= s4_side_in;
      s4_pp_ff   <= s3_pp_ff;
      s5_aa_ff   <= s5_aa_in;
      s5_ap5_ff  <= s5_ap5_in;
      s5_ap2_ff  <= s5_ap2_in;
      s5_side_ff <= s4_side_ff;
      s5_pp_ff   <= s4_pp_ff;
      s6_m6_ff   <= s6_m6_in;
      s6_m3b_ff  <= s6_m3b_in;
      s6_ap5_ff  <= s5_ap5_ff;
      s6_ap2_ff  <= s5_ap2_ff;
      s6_side_ff <= s5_side_ff;
      s6_pp_ff   <= s5_pp_ff;
      s7_b_ff    <= s7_b_in;
      s7_x_ff    <= s7_x_in;
      s7_side_ff <= s6_side_ff;
      s7_pp_ff   <= s6_pp_ff;
      s8_lo_ff   <= s8_lo_in;
      s8_hi_ff   <= s8_hi_in;
      s8_n0_ff   <= s8_n0_in;
      s8_side_ff <= s7_side_ff;
      s9_div_ff  <= prod[63:33];
      s9_nl_ff   <= s9_nl_in;
      s9_nh_ff   <= s9_nh_in;
      s9_side_ff <= s8_side_ff;
      s10_n_ff   <= s10_n_in;
      s10_div_ff <= s9_div_ff;
      s10_side_ff <= s9_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff[0].v <= 1'b0;
      end else begin
         div_ff[0] <= div0_in;
      end
   end

   // ---------------- restoring divider, one bit per stage ----------------
   function automatic div_stage_type div_step(input div_stage_type s);
      logic [31:0]   trial;
      logic          ge;
      div_stage_type r;
      trial   = {s.rem, s.dvd[63]};
      ge      = (trial >= {1'b0, s.mag_d});
      r       = s;
      r.rem   = ge ? 31'(trial - {1'b0, s.mag_d}) : trial[30:0];
      r.dvd   = {s.dvd[62:0], ge};
      return r;
   endfunction

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[k+1].v <= 1'b0;
         end else begin
            div_ff[k+1] <= div_step(div_ff[k]);
         end
      end
   end

   // ---------------- back stages ----------------
   logic [BACK_STAGES-2:0] bv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= '0;
      end else begin
         bv_ff <= {bv_ff[BACK_STAGES-3:0], div_ff[DIV_BITS].v};
      end
   end

   // Q: signed quotient, wraps modulo 2^64
   logic [63:0] q_q_in, q_q_ff;
   logic        q_fault_ff;
   side_type    q_side_ff;
   assign q_q_in = div_ff[DIV_BITS].neg ? (~div_ff[DIV_BITS].dvd + 64'd1)
                                        : div_ff[DIV_BITS].dvd;

   // D1: s = q >>> 13 split in 32 + 19 bits
   logic [31:0]        sl;
   logic signed [18:0] sh;
   logic [63:0]        d1_slsl_in, d1_slsl_ff;
   logic signed [51:0] d1_slsh_in;
   logic [30:0]        d1_slsh_ff;
   logic signed [48:0] d1_qlp8_in, d1_qlp8_ff;
   logic signed [47:0] d1_qhp8_in;
   logic [31:0]        d1_qhp8_ff;
   logic [63:0]        d1_q_ff;
   logic               d1_fault_ff;
   side_type           d1_side_ff;
   assign sl         = q_q_ff[44:13];
   assign sh         = q_q_ff[63:45];
   assign d1_slsl_in = sl * sl;
   assign d1_slsh_in = $signed({1'b0, sl}) * sh;
   assign d1_qlp8_in = $signed({1'b0, q_q_ff[31:0]}) * p8;
   assign d1_qhp8_in = $signed(q_q_ff[63:32]) * p8;

   // D2: s*s and p8 term
   logic [63:0] d2_ss_in, d2_ss_ff, pb, d2_bt_in, d2_bt_ff, d2_q_ff;
   logic        d2_fault_ff;
   side_type    d2_side_ff;
   assign d2_ss_in = d1_slsl_ff + {d1_slsh_ff, 33'b0};
   assign pb       = {{15{d1_qlp8_ff[48]}}, d1_qlp8_ff} + {d1_qhp8_ff, 32'b0};
   assign d2_bt_in = $signed(pb) >>> 19;

   // D3: times p9
   logic signed [48:0] d3_lp9_in, d3_lp9_ff;
   logic signed [47:0] d3_hp9_in;
   logic [31:0]        d3_hp9_ff;
   logic [63:0]        d3_bt_ff, d3_q_ff;
   logic               d3_fault_ff;
   side_type           d3_side_ff;
   assign d3_lp9_in = $signed({1'b0, d2_ss_ff[31:0]}) * p9;
   assign d3_hp9_in = $signed(d2_ss_ff[63:32]) * p9;

   // D4: sum of the three terms
   logic [63:0] xa, at, d4_sum_in, d4_sum_ff;
   logic        d4_fault_ff;
   side_type    d4_side_ff;
   assign xa        = {{15{d3_lp9_ff[48]}}, d3_lp9_ff} + {d3_hp9_ff, 32'b0};
   assign at        = $signed(xa) >>> 25;
   assign d4_sum_in = d3_q_ff + at + d3_bt_ff;

   // D5: final shift and offset, low 32 bits only
   logic [31:0] press;
   assign press = d4_sum_ff[39:8] + {{12{p7[15]}}, p7, 4'b0};

   logic        rsp_valid_ff, rsp_fault_ff;
   logic [31:0] rsp_temp_ff, rsp_fine_ff, rsp_press_ff;

   always_ff @(posedge clock) begin
      q_q_ff      <= q_q_in;
      q_fault_ff  <= div_ff[DIV_BITS].fault;
      q_side_ff   <= div_ff[DIV_BITS].side;
      d1_slsl_ff  <= d1_slsl_in;
      d1_slsh_ff  <= d1_slsh_in[30:0];
      d1_qlp8_ff  <= d1_qlp8_in;
      d1_qhp8_ff  <= d1_qhp8_in[31:0];
      d1_q_ff     <= q_q_ff;
      d1_fault_ff <= q_fault_ff;
      d1_side_ff  <= q_side_ff;
      d2_ss_ff    <= d2_ss_in;
      d2_bt_ff    <= d2_bt_in;
      d2_q_ff     <= d1_q_ff;
      d2_fault_ff <= d1_fault_ff;
      d2_side_ff  <= d1_side_ff;
      d3_lp9_ff   <= d3_lp9_in;
      d3_hp9_ff   <= d3_hp9_in[31:0];
      d3_bt_ff    <= d2_bt_ff;
      d3_q_ff     <= d2_q_ff;
      d3_fault_ff <= d2_fault_ff;
      d3_side_ff  <= d2_side_ff;
      d4_sum_ff   <= d4_sum_in;
      d4_fault_ff <= d3_fault_ff;
      d4_side_ff  <= d3_side_ff;
      rsp_fault_ff <= d4_fault_ff;
      rsp_press_ff <= d4_fault_ff ? 32'd0 : press;
      rsp_temp_ff  <= d4_side_ff.temp;
      rsp_fine_ff  <= {{7{d4_side_ff.fine[24]}}, d4_side_ff.fine};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= bv_ff[BACK_STAGES-2];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = rsp_temp_ff;
   assign rsp_fine_temperature  = rsp_fine_ff;
   assign rsp_pressure_q24_8    = rsp_press_ff;
   assign rsp_divide_fault      = rsp_fault_ff;

endmodule

@@ rtl/ptc_checker.sv @@
// Port-level checks for the trim compensation block, bound to its top level.
// Depends on ptc_pkg for the pipeline latency.
`timescale 1ns / 1ps

module ptc_checker import ptc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_start,
   input logic        req_busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_pressure_q24_8,
   input logic        rsp_divide_fault
);

   // every accepted item comes out after the fixed latency
   a_item_out: assert property (@(posedge clock) disable iff (reset)
      (req_start && !req_busy) |-> ##LATENCY rsp_valid)
      else $error("accepted item produced no result");

   // no result without an item accepted the pipeline latency earlier
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_start && !req_busy, LATENCY))
      else $error("result without accepted item");

   // a divide fault forces zero pressure
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_fault) |-> (rsp_pressure_q24_8 == 32'd0))
      else $error("divide fault with nonzero pressure");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (.*);
